// ----- rtl/vco_pkg.sv -----
// Shared widths, limits and types of the velocity clip block.
package vco_pkg;

  localparam int FRAC_BITS_DEF   = 16;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam int V_W    = 32;          // velocity / result component
  localparam int N_W    = 19;          // normal component
  localparam int BF_W   = 20;          // overbounce factor
  localparam int PROD_W = V_W + N_W;   // one velocity * normal product
  localparam int DOT_W  = PROD_W + 2;  // sum of three products
  localparam int B_W    = 45;          // raw backoff after the first shift
  localparam int DD_W   = 51;          // dividend of the backoff divide
  localparam int PB_W   = B_W + BF_W + 1;
  localparam int BFIN_W = 46;          // clamped backoff, +-2^44
  localparam int NB_W   = N_W + BFIN_W;
  localparam int DF_W   = NB_W + 1;
  localparam int LEN2_W = 64;          // squared length
  localparam int LEN_W  = 32;          // length
  localparam int SC_W   = 63;          // magnitude * old length

  localparam longint BACKOFF_LIM = 64'sd17592186044416;  // 2^44

  typedef struct packed {
    logic signed [V_W-1:0]  vel_x;
    logic signed [V_W-1:0]  vel_y;
    logic signed [V_W-1:0]  vel_z;
    logic signed [N_W-1:0]  norm_x;
    logic signed [N_W-1:0]  norm_y;
    logic signed [N_W-1:0]  norm_z;
    logic [BF_W-1:0]        bounce;
    logic signed [B_W-1:0]  backoff;
    logic                   pos;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ----- rtl/vco_if.sv -----
// Input and result channel interfaces of the velocity clip block.
interface vco_in_if;
  import vco_pkg::*;
  logic                  valid;
  logic                  ready;
  logic signed [V_W-1:0] vel_x;
  logic signed [V_W-1:0] vel_y;
  logic signed [V_W-1:0] vel_z;
  logic signed [N_W-1:0] norm_x;
  logic signed [N_W-1:0] norm_y;
  logic signed [N_W-1:0] norm_z;
  logic [BF_W-1:0]       bounce_factor;
  modport source (output valid, vel_x, vel_y, vel_z, norm_x, norm_y, norm_z, bounce_factor,
                  input ready);
  modport sink (input valid, vel_x, vel_y, vel_z, norm_x, norm_y, norm_z, bounce_factor,
                output ready);
endinterface

interface vco_out_if;
  import vco_pkg::*;
  logic                  valid;
  logic                  ready;
  logic signed [V_W-1:0] res_x;
  logic signed [V_W-1:0] res_y;
  logic signed [V_W-1:0] res_z;
  logic                  rescaled;
  modport source (output valid, res_x, res_y, res_z, rescaled, input ready);
  modport sink (input valid, res_x, res_y, res_z, rescaled, output ready);
endinterface

// ----- rtl/vco_div.sv -----
// Pipelined restoring divider, one quotient bit per stage.
module vco_div #(
  parameter int NW = vco_pkg::DD_W,
  parameter int DW = vco_pkg::BF_W,
  parameter int PW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_vld,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [PW-1:0] in_pay,
  output logic          out_vld,
  output logic [NW-1:0] quo,
  output logic [PW-1:0] out_pay
);

  logic [NW-1:0] vld_r;
  logic [NW-1:0] acc_r [NW];
  logic [PW-1:0] pay_r [NW];
  logic [DW-1:0] rem_r [NW-1];
  logic [DW-1:0] den_r [NW-1];

  for (genvar s = 0; s < NW; s++) begin : g_stg
    logic [NW-1:0] acc_i;
    logic [DW-1:0] rem_i;
    logic [DW-1:0] den_i;
    logic [PW-1:0] pay_i;
    logic          vld_i;
    logic [DW:0]   trial;
    logic          ge;

    if (s == 0) begin : g_first
      assign acc_i = num;
      assign rem_i = '0;
      assign den_i = den;
      assign pay_i = in_pay;
      assign vld_i = in_vld;
    end else begin : g_rest
      assign acc_i = acc_r[s-1];
      assign rem_i = rem_r[s-1];
      assign den_i = den_r[s-1];
      assign pay_i = pay_r[s-1];
      assign vld_i = vld_r[s-1];
    end

    assign trial = {rem_i, acc_i[NW-1]};
    assign ge    = trial >= {1'b0, den_i};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        acc_r[s] <= {acc_i[NW-2:0], ge};
        pay_r[s] <= pay_i;
      end
    end

    if (s < NW - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[s] <= ge ? DW'(trial - {1'b0, den_i}) : trial[DW-1:0];
          den_r[s] <= den_i;
        end
      end
    end
  end

  assign out_vld = vld_r[NW-1];
  assign quo     = acc_r[NW-1];
  assign out_pay = pay_r[NW-1];

endmodule

// ----- rtl/vco_sqrt.sv -----
// Pipelined integer square root, one root bit per stage.
module vco_sqrt #(
  parameter int OW = vco_pkg::LEN_W,
  parameter int PW = 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_vld,
  input  logic [2*OW-1:0] rad,
  input  logic [PW-1:0]   in_pay,
  output logic            out_vld,
  output logic [OW-1:0]   root,
  output logic [PW-1:0]   out_pay
);

  localparam int RW = OW + 2;

  logic [OW-1:0]   vld_r;
  logic [OW-1:0]   root_r [OW];
  logic [PW-1:0]   pay_r  [OW];
  logic [2*OW-1:0] acc_r  [OW-1];
  logic [RW-1:0]   rem_r  [OW-1];

  for (genvar s = 0; s < OW; s++) begin : g_stg
    logic [2*OW-1:0] acc_i;
    logic [RW-1:0]   rem_i;
    logic [OW-1:0]   root_i;
    logic [PW-1:0]   pay_i;
    logic            vld_i;
    logic [RW+1:0]   trial;
    logic [RW+1:0]   test;
    logic            ge;

    if (s == 0) begin : g_first
      assign acc_i  = rad;
      assign rem_i  = '0;
      assign root_i = '0;
      assign pay_i  = in_pay;
      assign vld_i  = in_vld;
    end else begin : g_rest
      assign acc_i  = acc_r[s-1];
      assign rem_i  = rem_r[s-1];
      assign root_i = root_r[s-1];
      assign pay_i  = pay_r[s-1];
      assign vld_i  = vld_r[s-1];
    end

    assign trial = {rem_i, acc_i[2*OW-1 -: 2]};
    assign test  = (RW+2)'({root_i, 2'b01});
    assign ge    = trial >= test;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        root_r[s] <= {root_i[OW-2:0], ge};
        pay_r[s]  <= pay_i;
      end
    end

    if (s < OW - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[s] <= ge ? RW'(trial - test) : RW'(trial);
          acc_r[s] <= {acc_i[2*OW-3:0], 2'b00};
        end
      end
    end
  end

  assign out_vld = vld_r[OW-1];
  assign root    = root_r[OW-1];
  assign out_pay = pay_r[OW-1];

endmodule

// ----- rtl/vco_front.sv -----
// Front end: takes words, forms the backoff and classifies its sign.
module vco_front #(
  parameter int FRAC_BITS = vco_pkg::FRAC_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  vco_in_if.sink           in_ch,
  input  vco_pkg::q_stat_t q_stat,
  output logic             push,
  output vco_pkg::item_t   push_item
);
  import vco_pkg::*;

  logic                     adv;
  logic                     s1_vld_r;
  logic signed [PROD_W-1:0] s1_px_r, s1_py_r, s1_pz_r;
  logic signed [V_W-1:0]    s1_vx_r, s1_vy_r, s1_vz_r;
  logic signed [N_W-1:0]    s1_nx_r, s1_ny_r, s1_nz_r;
  logic [BF_W-1:0]          s1_bf_r;
  logic                     s2_vld_r;
  item_t                    s2_item_r;
  item_t                    s2_item_nxt;
  logic signed [DOT_W-1:0]  dot;
  logic signed [B_W-1:0]    bko;

  // Advance while the classified word can leave or the slot is empty.
  assign adv         = !s2_vld_r || !q_stat.full;
  assign in_ch.ready = adv;
  assign push        = s2_vld_r && !q_stat.full;
  assign push_item   = s2_item_r;

  always_comb begin
    dot = DOT_W'(s1_px_r) + DOT_W'(s1_py_r) + DOT_W'(s1_pz_r);
    bko = B_W'(dot >>> FRAC_BITS);
    s2_item_nxt.vel_x   = s1_vx_r;
    s2_item_nxt.vel_y   = s1_vy_r;
    s2_item_nxt.vel_z   = s1_vz_r;
    s2_item_nxt.norm_x  = s1_nx_r;
    s2_item_nxt.norm_y  = s1_ny_r;
    s2_item_nxt.norm_z  = s1_nz_r;
    s2_item_nxt.bounce  = s1_bf_r;
    s2_item_nxt.backoff = bko;
    s2_item_nxt.pos     = !bko[B_W-1] && (bko != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= in_ch.valid;
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_px_r   <= PROD_W'(in_ch.vel_x) * PROD_W'(in_ch.norm_x);
      s1_py_r   <= PROD_W'(in_ch.vel_y) * PROD_W'(in_ch.norm_y);
      s1_pz_r   <= PROD_W'(in_ch.vel_z) * PROD_W'(in_ch.norm_z);
      s1_vx_r   <= in_ch.vel_x;
      s1_vy_r   <= in_ch.vel_y;
      s1_vz_r   <= in_ch.vel_z;
      s1_nx_r   <= in_ch.norm_x;
      s1_ny_r   <= in_ch.norm_y;
      s1_nz_r   <= in_ch.norm_z;
      s1_bf_r   <= in_ch.bounce_factor;
      s2_item_r <= s2_item_nxt;
    end
  end

endmodule

// ----- rtl/vco_queue.sv -----
// Short queue of classified words between the front and back ends.
module vco_queue #(
  parameter int DEPTH = vco_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  vco_pkg::item_t   push_item,
  input  logic             pop,
  output vco_pkg::item_t   pop_item,
  output vco_pkg::q_stat_t stat
);
  import vco_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  item_t         mem [DEPTH];
  logic [AW-1:0] wptr_r, rptr_r;
  logic [CW-1:0] cnt_r;

  assign stat.full  = cnt_r == CW'(DEPTH);
  assign stat.empty = cnt_r == '0;
  assign pop_item   = mem[rptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) begin
        wptr_r <= (wptr_r == AW'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
      end
      if (pop) begin
        rptr_r <= (rptr_r == AW'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n) push |-> !stat.full)
    else $error("queue written while full");
  a_pop_data: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !stat.empty)
    else $error("queue read while empty");
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> cnt_r == CW'($past(cnt_r) + 1'b1))
    else $error("queue count did not follow a lone write");
`endif

endmodule

// ----- rtl/vco_back.sv -----
// Back end: applies the overbounce, clips, and rescales to the original speed.
module vco_back #(
  parameter int FRAC_BITS = vco_pkg::FRAC_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  vco_pkg::item_t   item,
  input  vco_pkg::q_stat_t q_stat,
  output logic             pop,
  vco_out_if.source        out_ch
);
  import vco_pkg::*;

  typedef struct packed {
    logic                   pos;
    logic signed [PB_W-1:0] pb;
    logic signed [V_W-1:0]  v0;
    logic signed [V_W-1:0]  v1;
    logic signed [V_W-1:0]  v2;
    logic signed [N_W-1:0]  n0;
    logic signed [N_W-1:0]  n1;
    logic signed [N_W-1:0]  n2;
  } d1_pay_t;

  localparam logic signed [PB_W-1:0]   PB_HI = PB_W'(BACKOFF_LIM);
  localparam logic signed [PB_W-1:0]   PB_LO = -PB_HI;
  localparam logic signed [BFIN_W-1:0] B_HI  = BFIN_W'(BACKOFF_LIM);
  localparam logic signed [BFIN_W-1:0] B_LO  = -B_HI;
  localparam logic signed [DF_W-1:0]   S_MAX = DF_W'(64'sd2147483647);
  localparam logic signed [DF_W-1:0]   S_MIN = DF_W'(-64'sd2147483648);

  function automatic logic signed [V_W-1:0] sat32(input logic signed [DF_W-1:0] x);
    logic signed [V_W-1:0] r;
    if (x > S_MAX) begin
      r = S_MAX[V_W-1:0];
    end else if (x < S_MIN) begin
      r = S_MIN[V_W-1:0];
    end else begin
      r = x[V_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [V_W-1:0] mag32(input logic signed [V_W-1:0] x);
    return x[V_W-1] ? (~x + 1'b1) : x;
  endfunction

  logic adv;

  // Entry stage registers.
  logic                   b1_vld_r;
  logic [DD_W-1:0]        b1_dd_r;
  logic [BF_W-1:0]        b1_dv_r;
  d1_pay_t                b1_pay_r;
  // Backoff divider outputs.
  logic                   d1_vld;
  logic [DD_W-1:0]        d1_quo;
  logic [$bits(d1_pay_t)-1:0] d1_pay_raw;
  d1_pay_t                d1_pay;
  // Merged backoff.
  logic                   m_vld_r;
  logic signed [BFIN_W-1:0] m_b_r;
  logic signed [BFIN_W-1:0] m_b_nxt;
  logic signed [PB_W-1:0]   m_sh;
  logic signed [V_W-1:0]  m_v_r [3];
  logic signed [N_W-1:0]  m_n_r [3];
  // Normal times backoff.
  logic                   p_vld_r;
  logic signed [NB_W-1:0] p_nb_r [3];
  logic signed [V_W-1:0]  p_v_r  [3];
  // Clipped vector.
  logic                   o_vld_r;
  logic signed [V_W-1:0]  o_o_r [3];
  logic signed [V_W-1:0]  o_v_r [3];
  // Squares.
  logic                   s_vld_r;
  logic [LEN2_W-1:0]      s_sv_r [3];
  logic [LEN2_W-1:0]      s_so_r [3];
  logic signed [V_W-1:0]  s_o_r  [3];
  // Squared lengths.
  logic                   a_vld_r;
  logic [LEN2_W-1:0]      a_old2_r, a_new2_r;
  logic signed [V_W-1:0]  a_o_r [3];
  // Lengths.
  logic                   q0_vld, q1_vld;
  logic [LEN_W-1:0]       l1_raw, l0;
  logic [V_W:0]           q0_pay;
  logic [2*V_W-1:0]       q1_pay;
  // Scaled magnitudes.
  logic                   x_vld_r;
  logic [SC_W-1:0]        x_sc_r [3];
  logic [LEN_W-1:0]       x_l1_r;
  logic signed [V_W-1:0]  x_o_r  [3];
  logic                   x_resc_r;
  // Rescale dividers.
  logic [2:0]             r_vld;
  logic [SC_W-1:0]        r_quo [3];
  logic [V_W:0]           r_pay0;
  logic [V_W-1:0]         r_pay1, r_pay2;
  logic signed [V_W-1:0]  r_o [3];
  logic                   r_resc;
  logic signed [V_W-1:0]  r_res [3];
  // Output register.
  logic                   out_vld_r;
  logic signed [V_W-1:0]  out_res_r [3];
  logic                   out_resc_r;

  // Whole back end moves together; the output register parts it from the sink.
  assign adv = !out_vld_r || out_ch.ready;
  assign pop = adv && !q_stat.empty;

  // Entry: form the nonpositive-branch product and the divide operands.
  always_ff @(posedge clk) begin
    if (adv) begin
      b1_pay_r.pos <= item.pos;
      b1_pay_r.pb  <= PB_W'(item.backoff) * PB_W'($signed({1'b0, item.bounce}));
      b1_pay_r.v0  <= item.vel_x;
      b1_pay_r.v1  <= item.vel_y;
      b1_pay_r.v2  <= item.vel_z;
      b1_pay_r.n0  <= item.norm_x;
      b1_pay_r.n1  <= item.norm_y;
      b1_pay_r.n2  <= item.norm_z;
      b1_dd_r      <= DD_W'($unsigned(item.backoff)) << FRAC_BITS;
      b1_dv_r      <= (item.bounce == '0) ? BF_W'(1) : item.bounce;
    end
  end

  vco_div #(.NW(DD_W), .DW(BF_W), .PW($bits(d1_pay_t))) u_bdiv (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .in_vld  (b1_vld_r),
    .num     (b1_dd_r),
    .den     (b1_dv_r),
    .in_pay  (b1_pay_r),
    .out_vld (d1_vld),
    .quo     (d1_quo),
    .out_pay (d1_pay_raw)
  );

  assign d1_pay = d1_pay_raw;

  // Pick the branch and clamp the backoff to +-2^44.
  always_comb begin
    m_sh = d1_pay.pb >>> FRAC_BITS;
    if (d1_pay.pos) begin
      m_b_nxt = (d1_quo > DD_W'(BACKOFF_LIM)) ? B_HI : BFIN_W'(d1_quo);
    end else if (m_sh < PB_LO) begin
      m_b_nxt = B_LO;
    end else if (m_sh > PB_HI) begin
      m_b_nxt = B_HI;
    end else begin
      m_b_nxt = BFIN_W'(m_sh);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_b_r    <= m_b_nxt;
      m_v_r[0] <= d1_pay.v0;
      m_v_r[1] <= d1_pay.v1;
      m_v_r[2] <= d1_pay.v2;
      m_n_r[0] <= d1_pay.n0;
      m_n_r[1] <= d1_pay.n1;
      m_n_r[2] <= d1_pay.n2;
      for (int i = 0; i < 3; i++) begin
        p_nb_r[i] <= NB_W'(m_n_r[i]) * NB_W'(m_b_r);
        p_v_r[i]  <= m_v_r[i];
        o_o_r[i]  <= sat32(DF_W'(p_v_r[i]) - DF_W'(p_nb_r[i] >>> FRAC_BITS));
        o_v_r[i]  <= p_v_r[i];
        s_sv_r[i] <= LEN2_W'(mag32(o_v_r[i])) * LEN2_W'(mag32(o_v_r[i]));
        s_so_r[i] <= LEN2_W'(mag32(o_o_r[i])) * LEN2_W'(mag32(o_o_r[i]));
        s_o_r[i]  <= o_o_r[i];
        a_o_r[i]  <= s_o_r[i];
      end
      a_old2_r <= s_sv_r[0] + s_sv_r[1] + s_sv_r[2];
      a_new2_r <= s_so_r[0] + s_so_r[1] + s_so_r[2];
    end
  end

  // Lengths of the new (lane 0) and old (lane 1) vectors; the test rides along.
  vco_sqrt #(.OW(LEN_W), .PW(V_W + 1)) u_sq_new (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .in_vld  (a_vld_r),
    .rad     (a_new2_r),
    .in_pay  ({a_new2_r > a_old2_r, a_o_r[0]}),
    .out_vld (q0_vld),
    .root    (l1_raw),
    .out_pay (q0_pay)
  );

  vco_sqrt #(.OW(LEN_W), .PW(2 * V_W)) u_sq_old (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .in_vld  (a_vld_r),
    .rad     (a_old2_r),
    .in_pay  ({a_o_r[1], a_o_r[2]}),
    .out_vld (q1_vld),
    .root    (l0),
    .out_pay (q1_pay)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      x_resc_r <= q0_pay[V_W];
      x_o_r[0] <= q0_pay[V_W-1:0];
      x_o_r[1] <= q1_pay[2*V_W-1:V_W];
      x_o_r[2] <= q1_pay[V_W-1:0];
      x_sc_r[0] <= SC_W'(LEN2_W'(mag32(q0_pay[V_W-1:0])) * LEN2_W'(l0));
      x_sc_r[1] <= SC_W'(LEN2_W'(mag32(q1_pay[2*V_W-1:V_W])) * LEN2_W'(l0));
      x_sc_r[2] <= SC_W'(LEN2_W'(mag32(q1_pay[V_W-1:0])) * LEN2_W'(l0));
      x_l1_r    <= (l1_raw == '0) ? LEN_W'(1) : l1_raw;
    end
  end

  vco_div #(.NW(SC_W), .DW(LEN_W), .PW(V_W + 1)) u_rdiv0 (
    .clk (clk), .rst_n (rst_n), .en (adv), .in_vld (x_vld_r),
    .num (x_sc_r[0]), .den (x_l1_r), .in_pay ({x_resc_r, x_o_r[0]}),
    .out_vld (r_vld[0]), .quo (r_quo[0]), .out_pay (r_pay0)
  );

  vco_div #(.NW(SC_W), .DW(LEN_W), .PW(V_W)) u_rdiv1 (
    .clk (clk), .rst_n (rst_n), .en (adv), .in_vld (x_vld_r),
    .num (x_sc_r[1]), .den (x_l1_r), .in_pay (x_o_r[1]),
    .out_vld (r_vld[1]), .quo (r_quo[1]), .out_pay (r_pay1)
  );

  vco_div #(.NW(SC_W), .DW(LEN_W), .PW(V_W)) u_rdiv2 (
    .clk (clk), .rst_n (rst_n), .en (adv), .in_vld (x_vld_r),
    .num (x_sc_r[2]), .den (x_l1_r), .in_pay (x_o_r[2]),
    .out_vld (r_vld[2]), .quo (r_quo[2]), .out_pay (r_pay2)
  );

  // Restore the sign on the shortened magnitude, or keep the clipped value.
  always_comb begin
    r_resc = r_pay0[V_W];
    r_o[0] = r_pay0[V_W-1:0];
    r_o[1] = r_pay1;
    r_o[2] = r_pay2;
    for (int i = 0; i < 3; i++) begin
      if (!r_resc) begin
        r_res[i] = r_o[i];
      end else if (r_o[i][V_W-1]) begin
        r_res[i] = -$signed(r_quo[i][V_W-1:0]);
      end else begin
        r_res[i] = $signed(r_quo[i][V_W-1:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_resc_r <= r_resc;
      for (int i = 0; i < 3; i++) begin
        out_res_r[i] <= r_res[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_vld_r  <= 1'b0;
      m_vld_r   <= 1'b0;
      p_vld_r   <= 1'b0;
      o_vld_r   <= 1'b0;
      s_vld_r   <= 1'b0;
      a_vld_r   <= 1'b0;
      x_vld_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      b1_vld_r  <= !q_stat.empty;
      m_vld_r   <= d1_vld;
      p_vld_r   <= m_vld_r;
      o_vld_r   <= p_vld_r;
      s_vld_r   <= o_vld_r;
      a_vld_r   <= s_vld_r;
      x_vld_r   <= q0_vld && q1_vld;
      out_vld_r <= &r_vld;
    end
  end

  assign out_ch.valid    = out_vld_r;
  assign out_ch.res_x    = out_res_r[0];
  assign out_ch.res_y    = out_res_r[1];
  assign out_ch.res_z    = out_res_r[2];
  assign out_ch.rescaled = out_resc_r;

endmodule

// ----- rtl/velocity_clip_overbounce.sv -----
// Top level of the velocity clip block: front end, queue and back end.
//
//   channel  | direction | handshake           | word
//   in_ch    | in        | valid / ready       | vel_x/y/z, norm_x/y/z, bounce_factor
//   out_ch   | out       | valid / ready       | res_x/y/z, rescaled
//
// One word is taken per cycle and one result leaves per cycle when the sink
// keeps ready high. Pipeline depth is set by the bit-per-stage backoff divider
// (51 stages), the two square roots (32 stages) and the rescale dividers
// (63 stages). Reset is synchronous and clears only valid bits, queue pointers
// and the queue count. A stalled sink freezes the back end; the queue then
// fills and in_ch.ready drops once the front end holds a word it cannot push.
module velocity_clip_overbounce #(
  parameter int FRAC_BITS   = vco_pkg::FRAC_BITS_DEF,
  parameter int QUEUE_DEPTH = vco_pkg::QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  vco_in_if.sink    in_ch,
  vco_out_if.source out_ch
);
  import vco_pkg::*;

  q_stat_t q_stat;
  logic    push;
  logic    pop;
  item_t   push_item;
  item_t   pop_item;

  // Classify each word by the sign of its backoff.
  vco_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .q_stat    (q_stat),
    .push      (push),
    .push_item (push_item)
  );

  // Hold classified words so either side can stall alone.
  vco_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .stat      (q_stat)
  );

  // Apply overbounce, clip, and rescale overlong results.
  vco_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .item   (pop_item),
    .q_stat (q_stat),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench of the velocity clip block: random and corner vectors against a predictor.
module tb_top;
  import vco_pkg::*;

  typedef struct packed {
    logic signed [V_W-1:0] vx, vy, vz;
    logic signed [N_W-1:0] nx, ny, nz;
    logic [BF_W-1:0]       bf;
  } clip_in_t;

  typedef struct packed {
    logic signed [V_W-1:0] rx, ry, rz;
    logic                  resc;
  } clip_res_t;

  localparam int F          = FRAC_BITS_DEF;
  localparam int IDLE_LIMIT = 20000;
  localparam int DRAIN_CYC  = 400;

  logic clk;
  logic rst_n;

  vco_in_if  in_ch ();
  vco_out_if out_ch ();

  velocity_clip_overbounce dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  clip_in_t  pending_words[$];
  clip_res_t expected_results[$];
  int        mismatch_cnt = 0;
  int        idle_cycles  = 0;
  bit        stim_done    = 0;
  logic      in_taken     = 1'b0;

  // floor(x / 2^F) on signed values
  function automatic longint floor_div_pow2(longint x);
    return x >>> F;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r;
    longint unsigned bitv;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= r + bitv) begin
        v -= r + bitv;
        r = (r >> 1) + bitv;
      end else begin
        r >>= 1;
      end
      bitv >>= 2;
    end
    return r;
  endfunction

  // Clip the velocity against the plane, then restore the original speed if it grew.
  function automatic clip_res_t predict_clip(clip_in_t w);
    longint          v[3], n[3], o[3];
    longint          dotp, boff, dvs;
    longint unsigned old2, new2, l0, l1, m, mv, mo;
    clip_res_t       r;
    v[0] = w.vx; v[1] = w.vy; v[2] = w.vz;
    n[0] = w.nx; n[1] = w.ny; n[2] = w.nz;
    dotp = 0;
    for (int i = 0; i < 3; i++) dotp += v[i] * n[i];
    boff = floor_div_pow2(dotp);
    if (boff <= 0) begin
      boff = floor_div_pow2(boff * longint'({1'b0, w.bf}));
    end else begin
      dvs  = (w.bf == 0) ? 1 : longint'({1'b0, w.bf});
      boff = (boff << F) / dvs;
    end
    if (boff > BACKOFF_LIM) boff = BACKOFF_LIM;
    if (boff < -BACKOFF_LIM) boff = -BACKOFF_LIM;
    old2 = 0;
    new2 = 0;
    for (int i = 0; i < 3; i++) begin
      o[i] = v[i] - floor_div_pow2(n[i] * boff);
      if (o[i] > 64'sd2147483647) o[i] = 64'sd2147483647;
      if (o[i] < -64'sd2147483648) o[i] = -64'sd2147483648;
      mv = (v[i] < 0) ? -v[i] : v[i];
      mo = (o[i] < 0) ? -o[i] : o[i];
      old2 += mv * mv;
      new2 += mo * mo;
    end
    r.resc = new2 > old2;
    if (r.resc) begin
      l0 = int_sqrt(old2);
      l1 = int_sqrt(new2);
      if (l1 == 0) l1 = 1;
      for (int i = 0; i < 3; i++) begin
        mo = (o[i] < 0) ? -o[i] : o[i];
        m = mo * l0 / l1;
        o[i] = (o[i] < 0) ? -longint'(m) : longint'(m);
      end
    end
    r.rx = o[0][31:0];
    r.ry = o[1][31:0];
    r.rz = o[2][31:0];
    return r;
  endfunction

  function automatic logic signed [N_W-1:0] rand_norm();
    return N_W'($signed($urandom_range(0, 262144)) - 131072);
  endfunction

  function automatic logic signed [V_W-1:0] rand_vel();
    case ($urandom_range(0, 3))
      0:       return $urandom;
      1:       return V_W'($signed($urandom_range(0, 2000000)) - 1000000);
      2:       return V_W'($signed($urandom_range(0, 200000000)) - 100000000);
      default: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
    endcase
  endfunction

  task automatic add_word(logic signed [V_W-1:0] vx, vy, vz,
                          logic signed [N_W-1:0] nx, ny, nz, logic [BF_W-1:0] bf);
    clip_in_t w;
    w = '{vx, vy, vz, nx, ny, nz, bf};
    pending_words.push_back(w);
  endtask

  // Clock and reset
  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    rst_n = 0;
    repeat (3) @(posedge clk);
    @(negedge clk) rst_n = 1;
  end

  // Stimulus: corners first, then mostly unit-ish normals with random content.
  initial begin
    logic signed [N_W-1:0] nx, ny, nz;
    add_word(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 19'sd131072, 19'sd131072,
             19'sd131072, 20'hfffff);
    add_word(32'sh80000000, 32'sh80000000, 32'sh80000000, -19'sd131072, -19'sd131072,
             -19'sd131072, 20'd1);
    add_word(32'sh80000000, 32'sh7fffffff, 0, 19'sd131072, -19'sd131072, 0, 20'd1);
    add_word(32'sh7fffffff, 0, 0, 19'sd65536, 0, 0, 20'd1);          // huge positive backoff
    add_word(32'sh80000000, 0, 0, 19'sd65536, 0, 0, 20'hfffff);      // overflowing component
    add_word(0, 0, 0, 0, 0, 0, 20'd65536);                            // zero vector
    add_word(32'sd65536, 0, 0, 19'sd65536, 0, 0, 20'd65536);          // positive backoff
    add_word(-32'sd65536, 0, 0, 19'sd65536, 0, 0, 20'd66846);         // overbounce 1.02
    add_word(32'sd100000, -32'sd300000, 32'sd5000, 0, 19'sd65536, 0, 20'd80000);
    add_word(32'sd123456, 32'sd654321, -32'sd98765, 19'sd37837, 19'sd37837, 19'sd37837,
             20'd65536);
    add_word(-32'sd1, -32'sd1, -32'sd1, -19'sd1, 19'sd1, -19'sd1, 20'd1);
    add_word(32'sd5000000, 0, 0, 19'sd40000, 19'sd40000, 0, 20'd300000); // non-unit normal
    add_word(32'sh55555555, 32'shaaaaaaaa, 32'sh0f0f0f0f, 19'sh2aaaa, 19'sh55555, 19'sh15555,
             20'h55555);
    add_word(32'shaaaaaaaa, 32'sh55555555, 32'shf0f0f0f0, 19'sh55555, 19'sh2aaaa, 19'sh6aaaa,
             20'haaaaa);
    for (int k = 0; k < 2000; k++) begin
      if ($urandom_range(0, 3) != 0) begin
        nx = N_W'($signed($urandom_range(0, 131072)) - 65536);
        ny = N_W'($signed($urandom_range(0, 131072)) - 65536);
        nz = N_W'($signed($urandom_range(0, 131072)) - 65536);
        add_word(rand_vel(), rand_vel(), rand_vel(), nx, ny, nz,
                 $urandom_range(0, 3) == 0 ? BF_W'($urandom_range(1, 20'hfffff))
                                           : BF_W'($urandom_range(60000, 72000)));
      end else begin
        add_word(rand_vel(), rand_vel(), rand_vel(), rand_norm(), rand_norm(), rand_norm(),
                 BF_W'($urandom_range(1, 20'hfffff)));
      end
    end
    stim_done = 1;
  end

  // Driver: bursts and gaps; advance to the next word on acceptance.
  int burst_left = 0;
  int gap_left   = 0;
  initial begin
    in_ch.valid = 0;
    {in_ch.vel_x, in_ch.vel_y, in_ch.vel_z} = '0;
    {in_ch.norm_x, in_ch.norm_y, in_ch.norm_z, in_ch.bounce_factor} = '0;
  end

  // Record whether the offered word was taken at the last rising edge.
  always @(posedge clk) begin
    in_taken <= in_ch.valid && in_ch.ready;
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && !in_taken) begin
        // hold the word until taken
      end else begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_ch.valid <= 0;
        end else if (pending_words.size() > 0) begin
          in_ch.valid         <= 1;
          in_ch.vel_x         <= pending_words[0].vx;
          in_ch.vel_y         <= pending_words[0].vy;
          in_ch.vel_z         <= pending_words[0].vz;
          in_ch.norm_x        <= pending_words[0].nx;
          in_ch.norm_y        <= pending_words[0].ny;
          in_ch.norm_z        <= pending_words[0].nz;
          in_ch.bounce_factor <= pending_words[0].bf;
          expected_results.push_back(predict_clip(pending_words[0]));
          void'(pending_words.pop_front());
          if (burst_left > 0) begin
            burst_left <= burst_left - 1;
          end else begin
            burst_left <= $urandom_range(0, 40);
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_ch.valid <= 0;
        end
      end
    end
  end

  // Receiver stall pattern; one long hold-off early on to fill the block.
  int  rx_cycle = 0;
  int  stall_left = 0;
  initial out_ch.ready = 0;

  always @(negedge clk) begin
    if (rst_n) begin
      rx_cycle <= rx_cycle + 1;
      if (rx_cycle >= 300 && rx_cycle < 800) begin
        out_ch.ready <= 0;
      end else if (stall_left > 0) begin
        stall_left   <= stall_left - 1;
        out_ch.ready <= 0;
      end else if ((rx_cycle / 1000) % 3 == 1) begin
        out_ch.ready <= 1;                       // stretch with no stalls
      end else if ($urandom_range(0, 9) == 0) begin
        stall_left   <= $urandom_range(1, 12);
        out_ch.ready <= 0;
      end else begin
        out_ch.ready <= 1;
      end
    end
  end

  // Monitor: compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    clip_res_t want;
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %h %h %h %b", $time, out_ch.res_x, out_ch.res_y,
                   out_ch.res_z, out_ch.rescaled);
          mismatch_cnt <= mismatch_cnt + 1;
        end else begin
          want = expected_results.pop_front();
          // the word in flight on the input is predicted at drive time, so skip nothing
          if (out_ch.res_x !== want.rx || out_ch.res_y !== want.ry ||
              out_ch.res_z !== want.rz || out_ch.rescaled !== want.resc) begin
            $display("%0t: mismatch expected %h %h %h %b actual %h %h %h %b", $time,
                     want.rx, want.ry, want.rz, want.resc, out_ch.res_x, out_ch.res_y,
                     out_ch.res_z, out_ch.rescaled);
            mismatch_cnt <= mismatch_cnt + 1;
          end
        end
      end
    end
  end

  // End of run and watchdog
  initial begin
    wait (stim_done);
    while (pending_words.size() > 0 || in_ch.valid || expected_results.size() > 0) begin
      @(posedge clk);
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("velocity_clip_overbounce test failed");
        $finish;
      end
    end
    repeat (DRAIN_CYC) @(posedge clk);
    if (mismatch_cnt == 0 && expected_results.size() == 0) begin
      $display("velocity_clip_overbounce test passed");
    end else begin
      $display("velocity_clip_overbounce test failed");
    end
    $finish;
  end
endmodule

// ----- files.f -----
rtl/vco_pkg.sv
rtl/vco_if.sv
rtl/vco_div.sv
rtl/vco_sqrt.sv
rtl/vco_front.sv
rtl/vco_queue.sv
rtl/vco_back.sv
rtl/velocity_clip_overbounce.sv
tb/sv/tb_top.sv
